[design/rrbc_pkg.sv]
// Shared types and constants for the ROM/RAM bank controller.
`timescale 1ns / 1ps
package rrbc_pkg;

	localparam int ROM_OFF_W    = 14;
	localparam int ROM_BANK_W   = 7;
	localparam int ROM_ADDR_W   = ROM_BANK_W + ROM_OFF_W;
	localparam int RAM_OFF_MAXW = 13;
	localparam int CFG_IDX_W    = 8;
	localparam int CFG_DATA_W   = 8;

	localparam logic [7:0] RAM_ENABLE_KEY = 8'h0A;
	localparam logic [4:0] LOW_BANK_MASK  = 5'h1F;

	typedef enum logic [1:0] {
		CMD_ROM_READ  = 2'd0,
		CMD_ROM_WRITE = 2'd1,
		CMD_RAM_READ  = 2'd2,
		CMD_RAM_WRITE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		RGN_RAM_ENABLE = 2'd0,
		RGN_LOW_BANK   = 2'd1,
		RGN_HIGH_BANK  = 2'd2,
		RGN_MODE       = 2'd3
	} region_t;

	localparam logic [CFG_IDX_W-1:0] REG_ROM_BANK_COUNT = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RAM_BANK_COUNT = 8'd1;

	typedef struct packed {
		logic                  ram_enabled;
		logic                  rom_mode;
		logic [ROM_BANK_W-1:0] rom_bank;
		logic [1:0]            ram_bank;
		logic [7:0]            rom_bank_count;
		logic [2:0]            ram_bank_count;
	} bank_state_t;

endpackage

[design/rrbc_ram.sv]
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps
module rrbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

[design/rrbc_bank_regs.sv]
// Bank, mode and enable registers with ROM-area write decode and configuration.
`timescale 1ns / 1ps
module rrbc_bank_regs
	import rrbc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  cmd_t                  command,
	input  logic [15:0]           address,
	input  logic [7:0]            write_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output bank_state_t           state
);

	bank_state_t state_q;
	logic        rom_wr;
	region_t     region;
	logic [4:0]  low_bits;

	assign rom_wr   = accept && (command == CMD_ROM_WRITE) && !address[15];
	assign region   = region_t'(address[14:13]);
	assign low_bits = ((write_data[4:0] & LOW_BANK_MASK) == 5'd0) ? 5'd1
	                                                             : write_data[4:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.ram_enabled    <= 1'b0;
			state_q.rom_mode       <= 1'b1;
			state_q.rom_bank       <= 7'd1;
			state_q.ram_bank       <= 2'd0;
			state_q.rom_bank_count <= 8'd2;
			state_q.ram_bank_count <= 3'd0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_ROM_BANK_COUNT) begin
					state_q.rom_bank_count <= cfg_data;
				end else if (cfg_index == REG_RAM_BANK_COUNT) begin
					state_q.ram_bank_count <= cfg_data[2:0];
				end
			end
			if (rom_wr) begin
				unique case (region)
					RGN_RAM_ENABLE: begin
						state_q.ram_enabled <= (write_data == RAM_ENABLE_KEY);
					end
					RGN_LOW_BANK: begin
						state_q.rom_bank <= {state_q.rom_bank[6:5], low_bits};
					end
					RGN_HIGH_BANK: begin
						if (state_q.rom_mode) begin
							state_q.rom_bank <= {write_data[1:0], state_q.rom_bank[4:0]};
						end else begin
							state_q.ram_bank <= write_data[1:0];
						end
					end
					RGN_MODE: begin
						state_q.rom_mode <= !write_data[0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign state = state_q;

endmodule

[design/rom_ram_bank_controller.sv]
// Top level of the ROM/RAM bank controller.
`timescale 1ns / 1ps
// Takes one bus access per clock while m_tready does not stall the output, and returns
// one result per access: the cartridge RAM read and the request fields are registered
// in stage 1, then the result goes to the output register. Bank registers update at the
// edge a ROM-area write is accepted, and the RAM is written at the edge a RAM write is
// accepted, so the next request already sees both. The result register stalls against
// m_tready without losing the RAM data. Cartridge RAM contents are undefined until written.
module rom_ram_bank_controller
	import rrbc_pkg::*;
#(
	parameter int RAM_BANK_BYTES = 8192,
	parameter int RAM_BANKS      = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [1:0]            s_tuser,   // command[1:0]
	input  logic [23:0]           s_tdata,   // address[15:0], write_data[23:16]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [31:0]           m_tdata,   // rom_address[20:0], read_data[28:21], ram_access_ok[29]
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int DEPTH = RAM_BANKS * RAM_BANK_BYTES;
	localparam int AW    = $clog2(DEPTH);
	localparam int OFF_W = $clog2(RAM_BANK_BYTES);

	cmd_t        command;
	logic [15:0] address;
	logic [7:0]  write_data;
	logic        accept;
	bank_state_t st;

	logic [2:0]            cnt_clamp;
	logic [1:0]            ram_bank_sel;
	logic [OFF_W-1:0]      ram_off;
	logic [31:0]           ram_idx_w;
	logic [AW-1:0]         ram_idx;
	logic                  allowed;
	logic                  is_ram;
	logic                  ram_en;
	logic                  ram_we;
	logic [7:0]            ram_rdata;
	logic [ROM_BANK_W-1:0] rom_bank_sel;
	logic [ROM_ADDR_W-1:0] rom_addr;

	logic                  v_s1;
	logic [ROM_ADDR_W-1:0] rom_addr_s1;
	logic                  ok_s1;
	logic                  rd_s1;
	logic                  out_v_q;
	logic [31:0]           out_data_q;
	logic                  adv_out;

	assign command    = cmd_t'(s_tuser);
	assign address    = s_tdata[15:0];
	assign write_data = s_tdata[23:16];

	assign adv_out  = !out_v_q || m_tready;
	assign s_tready = !v_s1 || adv_out;
	assign accept   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	rrbc_bank_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.command    (command),
		.address    (address),
		.write_data (write_data),
		.cfg_we     (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.state      (st)
	);

	assign cnt_clamp    = (32'(st.ram_bank_count) > RAM_BANKS) ? 3'(RAM_BANKS)
	                                                           : st.ram_bank_count;
	assign ram_bank_sel = st.ram_bank & 2'(cnt_clamp - 3'd1);
	assign ram_off      = address[OFF_W-1:0];
	assign ram_idx_w    = (32'(ram_bank_sel) << OFF_W) | 32'(ram_off);
	assign ram_idx      = ram_idx_w[AW-1:0];
	assign allowed      = st.ram_enabled && (st.ram_bank_count != 3'd0);
	assign is_ram       = (command == CMD_RAM_READ) || (command == CMD_RAM_WRITE);
	assign ram_en       = accept && is_ram && allowed;
	assign ram_we       = (command == CMD_RAM_WRITE);

	rrbc_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_idx),
		.wdata (write_data),
		.rdata (ram_rdata)
	);

	assign rom_bank_sel = address[15:14] != 2'd0
	                    ? st.rom_bank & (7'(st.rom_bank_count - 8'd1))
	                    : 7'd0;
	assign rom_addr     = (command == CMD_ROM_READ) ? {rom_bank_sel, address[ROM_OFF_W-1:0]}
	                                                : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (adv_out) begin
				v_s1 <= 1'b0;
			end
			if (adv_out) begin
				out_v_q <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rom_addr_s1 <= rom_addr;
			ok_s1       <= is_ram && allowed;
			rd_s1       <= (command == CMD_RAM_READ) && allowed;
		end
		if (adv_out && v_s1) begin
			out_data_q <= {2'b00, ok_s1, (rd_s1 ? ram_rdata : 8'd0), rom_addr_s1};
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;

endmodule

[design/rrbc_checker.sv]
// Port-level assertions for the ROM/RAM bank controller, bound to the top level.
`timescale 1ns / 1ps
module rrbc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[31:30] == 2'b00)
		else $error("result padding not zero");

	a_ram_no_rom: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[29] |-> m_tdata[20:0] == 21'd0)
		else $error("ram result carries a rom address");

	a_data_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[28:21] != 8'd0) |-> m_tdata[29])
		else $error("read data without an allowed ram access");

	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid && $past(!m_tvalid) && $past(!s_tvalid) && $past(arst_n) |-> s_tready)
		else $error("request stalled with an empty pipeline");

endmodule

bind rom_ram_bank_controller rrbc_checker u_rrbc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

[verif/tb.sv]
// Self-checking testbench for the ROM/RAM bank controller: scoreboard plus stream drivers.
`timescale 1ns / 1ps
module tb;
	import rrbc_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int NUM_PHASES  = 12;
	localparam int PHASE_ITEMS = 90;

	typedef struct packed {
		logic        ok;
		logic [7:0]  read_data;
		logic [20:0] rom_address;
	} bank_result_t;

	class bank_scoreboard;
		logic [7:0]   rom_count;
		logic [2:0]   ram_count;
		logic         ram_on;
		logic         rom_mode;
		logic [6:0]   rom_bank;
		logic [1:0]   ram_bank;
		logic [7:0]   store [0:32767];
		bit           filled [0:32767];
		bank_result_t expected_q [$];
		int           errors;
		int           checked;
		int           ram_hits;

		function new();
			rom_count = 8'd2;
			ram_count = 3'd0;
			ram_on    = 1'b0;
			rom_mode  = 1'b1;
			rom_bank  = 7'd1;
			ram_bank  = 2'd0;
			errors    = 0;
			checked   = 0;
			ram_hits  = 0;
			foreach (filled[i]) filled[i] = 1'b0;
		endfunction

		task report(string msg);
			errors++;
			$display("mismatch at %0t: %s", $realtime, msg);
		endtask

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == REG_ROM_BANK_COUNT)
				rom_count = val;
			else if (idx == REG_RAM_BANK_COUNT)
				ram_count = val[2:0];
		endfunction

		function logic [14:0] slot(logic [15:0] a);
			logic [2:0] cnt;
			logic [2:0] cmask;
			cnt   = (ram_count > 3'd4) ? 3'd4 : ram_count;
			cmask = cnt - 3'd1;
			return {ram_bank & cmask[1:0], a[12:0]};
		endfunction

		function bit allowed();
			return ram_on && ram_count != 3'd0;
		endfunction

		function bit holds(logic [15:0] a);
			return filled[slot(a)];
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note(cmd_t c, logic [15:0] a, logic [7:0] d);
			bank_result_t r;
			logic [7:0]   m;
			logic [6:0]   bank;
			logic [4:0]   low;
			r = '0;
			case (c)
				CMD_ROM_READ: begin
					m    = rom_count - 8'd1;
					bank = (a > 16'h3FFF) ? (rom_bank & m[6:0]) : 7'd0;
					r.rom_address = {bank, a[13:0]};
				end
				CMD_ROM_WRITE: begin
					if (a <= 16'h1FFF) begin
						ram_on = (d == RAM_ENABLE_KEY);
					end else if (a <= 16'h3FFF) begin
						low = d[4:0] & LOW_BANK_MASK;
						if (low == 5'd0)
							low = 5'd1;
						rom_bank = {rom_bank[6:5], low};
					end else if (a <= 16'h5FFF) begin
						if (rom_mode)
							rom_bank = {d[1:0], rom_bank[4:0]};
						else
							ram_bank = d[1:0];
					end else if (a <= 16'h7FFF) begin
						rom_mode = ~d[0];
					end
				end
				CMD_RAM_READ: begin
					if (allowed()) begin
						r.read_data = store[slot(a)];
						r.ok = 1'b1;
					end
				end
				default: begin
					if (allowed()) begin
						store[slot(a)]  = d;
						filled[slot(a)] = 1'b1;
						r.ok = 1'b1;
					end
				end
			endcase
			expected_q.push_back(r);
		endfunction

		task check(logic [31:0] t);
			bank_result_t got;
			bank_result_t want;
			got = t[29:0];
			if (expected_q.size() == 0) begin
				report($sformatf("result %h with nothing pending", t));
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (want.ok)
				ram_hits++;
			if (got.rom_address !== want.rom_address)
				report($sformatf("rom_address %h, want %h", got.rom_address, want.rom_address));
			if (got.read_data !== want.read_data)
				report($sformatf("read_data %h, want %h", got.read_data, want.read_data));
			if (got.ok !== want.ok)
				report($sformatf("ram_access_ok %b, want %b", got.ok, want.ok));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [1:0]            s_tuser;
	logic [23:0]           s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [31:0]           m_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bank_scoreboard sb;
	logic [15:0]    ram_addrs [$];
	bit             calm;
	bit             burst;
	bit             hold_req;
	int             sent;
	int             idle_cycles;

	rom_ram_bank_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_tready <= calm || ($urandom_range(99) >= 35);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check(m_tdata);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", STALL_LIMIT);
			$display("FAIL rom_ram_bank_controller");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_access(cmd_t c, logic [15:0] a, logic [7:0] d);
		s_tvalid <= 1'b1;
		s_tuser  <= c;
		s_tdata  <= {d, a};
		do @(posedge clk); while (!s_tready);
		sb.note(c, a, d);
		sent++;
		if (c == CMD_RAM_WRITE) begin
			ram_addrs.push_back(a);
			if (ram_addrs.size() > 64)
				void'(ram_addrs.pop_front());
		end
	endtask

	task automatic sender_gap();
		while (!calm && !burst && $urandom_range(99) < 35) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic access(cmd_t c, logic [15:0] a, logic [7:0] d);
		sender_gap();
		send_access(c, a, d);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
	endtask

	task automatic configure(logic [7:0] rom_cnt, logic [2:0] ram_cnt);
		if ($urandom_range(1)) begin
			write_reg(REG_ROM_BANK_COUNT, rom_cnt);
			write_reg(REG_RAM_BANK_COUNT, {5'd0, ram_cnt});
		end else begin
			write_reg(REG_RAM_BANK_COUNT, {5'd0, ram_cnt});
			write_reg(REG_ROM_BANK_COUNT, rom_cnt);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic random_access();
		int          pick;
		int          r;
		cmd_t        c;
		logic [15:0] a;
		logic [7:0]  d;
		pick = $urandom_range(99);
		r    = $urandom_range(9);
		d    = 8'($urandom_range(255));
		a    = 16'($urandom_range(65535));
		if (pick < 28) begin
			c = CMD_ROM_READ;
			case (r)
				0: a = 16'h3FFF;
				1: a = 16'h4000;
				2: a = 16'h7FFF;
				3: a = 16'h8000;
				default: ;
			endcase
		end else if (pick < 52) begin
			c = CMD_ROM_WRITE;
			case (r % 9)
				0, 1: begin
					a = 16'($urandom_range(16'h1FFF, 16'h0000));
					if ($urandom_range(3) != 0)
						d = RAM_ENABLE_KEY;
				end
				2, 3: begin
					a = 16'($urandom_range(16'h3FFF, 16'h2000));
					if ($urandom_range(4) == 0)
						d = {d[7:5], 5'd0};
				end
				4, 5: a = 16'($urandom_range(16'h5FFF, 16'h4000));
				6, 7: a = 16'($urandom_range(16'h7FFF, 16'h6000));
				default: a = 16'($urandom_range(16'hFFFF, 16'h8000));
			endcase
		end else begin
			c = (pick < 78) ? CMD_RAM_READ : CMD_RAM_WRITE;
			if (c == CMD_RAM_READ && ram_addrs.size() > 0 && r < 7)
				a = ram_addrs[$urandom_range(ram_addrs.size() - 1)];
			else if (r < 8)
				a = 16'hA000 + 16'($urandom_range(16'h1FFF));
			if ($urandom_range(4) == 0)
				a[15:13] = 3'($urandom_range(7));
			if (c == CMD_RAM_READ && sb.allowed() && !sb.holds(a))
				c = CMD_RAM_WRITE;
		end
		access(c, a, d);
	endtask

	initial begin
		logic [7:0] rom_counts [NUM_PHASES];
		logic [2:0] ram_counts [NUM_PHASES];
		rom_counts = '{8'd128, 8'd2, 8'd0, 8'd3, 8'd255, 8'd1,
			8'd64, 8'd16, 8'd4, 8'd32, 8'd128, 8'd8};
		ram_counts = '{3'd4, 3'd1, 3'd4, 3'd2, 3'd7, 3'd3,
			3'd5, 3'd0, 3'd6, 3'd2, 3'd4, 3'd1};
		sb = new();
		sent        = 0;
		calm        = 1'b0;
		burst       = 1'b0;
		hold_req    = 1'b0;
		idle_cycles <= 0;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tuser   <= '0;
		s_tdata   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: two ROM banks, no RAM
		access(CMD_ROM_READ, 16'h0000, 8'h00);
		access(CMD_ROM_READ, 16'h3FFF, 8'hFF);
		access(CMD_ROM_READ, 16'h4000, 8'h00);
		access(CMD_ROM_READ, 16'hFFFF, 8'h00);
		access(CMD_RAM_READ, 16'hA000, 8'h00);
		access(CMD_RAM_WRITE, 16'hBFFF, 8'hFF);
		drain();
		configure(8'd128, 3'd4);
		access(CMD_ROM_WRITE, 16'h0000, RAM_ENABLE_KEY);
		access(CMD_ROM_WRITE, 16'h2000, 8'h00);
		access(CMD_ROM_WRITE, 16'h4000, 8'h03);
		access(CMD_ROM_WRITE, 16'h3FFF, 8'h20);
		access(CMD_ROM_READ, 16'h7FFF, 8'h00);
		access(CMD_ROM_WRITE, 16'h2000, 8'h1F);
		access(CMD_ROM_READ, 16'h4000, 8'h00);
		access(CMD_ROM_WRITE, 16'h8000, 8'hFF);
		access(CMD_ROM_WRITE, 16'h6000, 8'h01);
		access(CMD_ROM_WRITE, 16'h5FFF, 8'h03);
		access(CMD_RAM_WRITE, 16'hA000, 8'h00);
		access(CMD_RAM_WRITE, 16'hBFFF, 8'hFF);
		access(CMD_RAM_READ, 16'hA000, 8'h00);
		access(CMD_RAM_READ, 16'h1FFF, 8'h00);
		access(CMD_RAM_WRITE, 16'hFFFF, 8'h5A);
		access(CMD_RAM_READ, 16'hBFFF, 8'h00);
		access(CMD_ROM_WRITE, 16'h7FFF, 8'hFE);
		access(CMD_ROM_WRITE, 16'h1FFF, 8'h0B);
		access(CMD_RAM_READ, 16'hA000, 8'h00);

		for (int p = 0; p < NUM_PHASES; p++) begin
			drain();
			configure(rom_counts[p], ram_counts[p]);
			calm = (p == 4);
			if (p == 2)
				hold_req = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				burst = (p == 2 && i < 80);
				random_access();
				if (p == 6 && i == PHASE_ITEMS / 2)
					drain();
			end
			burst = 1'b0;
		end
		calm = 1'b0;

		drain();
		repeat (8) @(posedge clk);
		$display("sent %0d accesses across %0d bank settings, checked %0d results",
			sent, NUM_PHASES + 2, sb.checked);
		$display("%0d of those results came through an open RAM window", sb.ram_hits);
		if (sb.errors == 0) begin
			$display("PASS rom_ram_bank_controller");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("FAIL rom_ram_bank_controller");
		end
		$finish;
	end
endmodule
